@@ design/lhq_pkg.sv @@
// package: types, constants and codes for the latency histogram quantile block
package lhq_pkg;
	localparam int unsigned BUCKETS_DEF    = 256;
	localparam int unsigned COUNT_BITS_DEF = 32;
	localparam int unsigned VAL_BITS       = 64;
	localparam int unsigned FRAC_BITS      = 32;
	localparam int unsigned CFG_IDX_BITS   = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 1'b1;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_IN    = 2'd1,
		ST_BELOW = 2'd2,
		ST_ABOVE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_DIV,
		S_REC_RD,
		S_REC_WR,
		S_MUL,
		S_QDIV,
		S_WALK_RD,
		S_WALK_CHK,
		S_BMUL,
		S_BOUND,
		S_OUT
	} state_t;
endpackage

@@ design/lhq_divider.sv @@
// unsigned restoring divider, one quotient bit per cycle
module lhq_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lhq_pkg::VAL_BITS-1:0] dividend,
	input  logic [lhq_pkg::FRAC_BITS-1:0] divisor,
	output logic                      busy,
	output logic                      done,
	output logic [lhq_pkg::VAL_BITS-1:0] quotient
);
	import lhq_pkg::*;

	localparam int unsigned CW = $clog2(VAL_BITS + 1);

	logic [VAL_BITS-1:0]  quo_q;
	logic [FRAC_BITS:0]   rem_q;
	logic [FRAC_BITS-1:0] dvs_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [FRAC_BITS:0]   trial;
	logic [FRAC_BITS:0]   diff;

	assign trial = {rem_q[FRAC_BITS-1:0], quo_q[VAL_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VAL_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[FRAC_BITS]) begin
				rem_q <= diff;
				quo_q <= {quo_q[VAL_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[VAL_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ design/lhq_multiplier.sv @@
// serial shift-add multiplier, 64 by 32 bits, one multiplier bit per cycle
module lhq_multiplier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lhq_pkg::VAL_BITS-1:0]  mcand,
	input  logic [lhq_pkg::FRAC_BITS-1:0] mplier,
	output logic                       done,
	output logic [lhq_pkg::VAL_BITS+lhq_pkg::FRAC_BITS-1:0] product
);
	import lhq_pkg::*;

	localparam int unsigned PW = VAL_BITS + FRAC_BITS;
	localparam int unsigned CW = $clog2(FRAC_BITS + 1);

	logic [PW-1:0]        acc_q;
	logic [PW-1:0]        mc_q;
	logic [FRAC_BITS-1:0] mp_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= PW'(mcand);
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[PW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[FRAC_BITS-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

@@ design/latency_histogram_quantile.sv @@
// top level: latency histogram with quantile query
// Usage: an item is taken when start is high and busy is low. op selects record or
// query. A record item below origin only bumps the counters and leaves busy low.
// Any other record item runs a bit-serial divide and, for an index inside the
// histogram, a read and a write of the count memory (states S_REC_RD, S_REC_WR)
// before it frees the block; an index past the last bucket frees the block after
// the divide. A record item gives no result.
// A query item multiplies count by numerator, divides by the denominator, walks
// the memory bucket by bucket (S_WALK_RD, then S_WALK_CHK) and multiplies index
// by width. The result strobe follows state S_OUT: straight from idle for a bad
// fraction or an empty store, after the divide for below range, after the walk
// and the multiply for a bucket in range, after walking all BUCKETS for above range;
// busy drops in the strobe cycle.
// The result is shown for one cycle with out_valid high; the receiver cannot stall.
// Configuration writes use cfg_valid/cfg_ready, index 0 origin, 1 bucket_width;
// cfg_ready is high while the block is idle and start is low.
// After reset a clearing pass writes zero to all BUCKETS entries, one per cycle,
// and busy stays high until the pass is over.
module latency_histogram_quantile #(
	parameter int unsigned BUCKETS    = lhq_pkg::BUCKETS_DEF,
	parameter int unsigned COUNT_BITS = lhq_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic signed [lhq_pkg::VAL_BITS-1:0] sample_value,
	input  logic [lhq_pkg::FRAC_BITS-1:0]       fraction_num,
	input  logic [lhq_pkg::FRAC_BITS-1:0]       fraction_den,
	output logic                                out_valid,
	output logic [1:0]                          status,
	output logic signed [lhq_pkg::VAL_BITS-1:0] lower_bound,
	output logic signed [lhq_pkg::VAL_BITS-1:0] upper_bound,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lhq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lhq_pkg::VAL_BITS-1:0]        cfg_data
);
	import lhq_pkg::*;

	localparam int unsigned IW = $clog2(BUCKETS);
	localparam int unsigned PW = VAL_BITS + FRAC_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [VAL_BITS-1:0] SMAX = {1'b0, {(VAL_BITS-1){1'b1}}};

	state_t state_q, state_d;

	logic signed [VAL_BITS-1:0] origin_q;
	logic [FRAC_BITS-1:0]       width_q;
	logic [COUNT_BITS-1:0]      total_q;
	logic [COUNT_BITS-1:0]      under_q;
	logic [COUNT_BITS-1:0]      mem [BUCKETS];
	logic [COUNT_BITS-1:0]      rd_q;
	logic [IW:0]                idx_q;
	logic [FRAC_BITS-1:0]       num_q;
	logic [FRAC_BITS-1:0]       den_q;
	logic [VAL_BITS-1:0]        off_q;
	logic [VAL_BITS-1:0]        thr_q;
	logic [VAL_BITS:0]          cum_q;
	logic [1:0]                 status_q;
	logic [VAL_BITS-1:0]        lo_q;
	logic [VAL_BITS-1:0]        hi_q;
	logic                       ov_q;
	logic                       valid_q;

	logic [FRAC_BITS-1:0]       weff;
	logic                       below;
	logic [VAL_BITS-1:0]        offset;
	logic [VAL_BITS-1:0]        quo;
	logic [PW-1:0]              prod;
	logic                       div_start;
	logic                       div_busy;
	logic                       div_done;
	logic                       mstart;
	logic                       mdone;
	logic [VAL_BITS-1:0]        div_a;
	logic [FRAC_BITS-1:0]       div_b;
	logic [VAL_BITS-1:0]        mul_a;
	logic [FRAC_BITS-1:0]       mul_b;
	logic [VAL_BITS:0]          cum_next;
	logic [VAL_BITS-1:0]        sum_lo;
	logic [VAL_BITS-1:0]        sum_hi;
	logic [VAL_BITS-1:0]        thr_fix;

	assign weff   = (width_q == '0) ? FRAC_BITS'(1) : width_q;
	assign below  = sample_value < origin_q;
	assign offset = VAL_BITS'(sample_value) - VAL_BITS'(origin_q);

	always_comb begin
		div_start = 1'b0;
		mstart    = 1'b0;
		div_a     = off_q;
		div_b     = weff;
		mul_a     = VAL_BITS'(total_q);
		mul_b     = num_q;
		if (state_q == S_MUL) begin
			div_a = prod[VAL_BITS-1:0] + VAL_BITS'(den_q) - VAL_BITS'(1);
			div_b = den_q;
		end
		if (state_q == S_WALK_CHK) begin
			mul_a = VAL_BITS'(idx_q[IW-1:0]);
			mul_b = weff;
		end
		if (state_q == S_IDLE && start && !busy && op == OP_RECORD && !below) begin
			div_start = 1'b1;
		end
		if (state_q == S_MUL && mdone) begin
			div_start = 1'b1;
		end
		if (state_q == S_IDLE && start && !busy && op == OP_QUERY) begin
			mstart = 1'b1;
		end
		if (state_q == S_WALK_CHK && cum_next >= {1'b0, thr_q}) begin
			mstart = 1'b1;
		end
	end

	lhq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_start && state_q == S_IDLE ? offset : div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	lhq_multiplier u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mstart),
		.mcand   (mstart && state_q == S_IDLE ? VAL_BITS'(total_q) : mul_a),
		.mplier  (mstart && state_q == S_IDLE ? fraction_num : mul_b),
		.done    (mdone),
		.product (prod)
	);

	assign cum_next = cum_q + (VAL_BITS+1)'(rd_q);
	assign thr_fix  = (quo == '0) ? VAL_BITS'(1) : quo;
	assign sum_lo   = VAL_BITS'(origin_q) + prod[VAL_BITS-1:0];
	assign sum_hi   = lo_q + VAL_BITS'(weff);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (idx_q == (IW+1)'(BUCKETS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (op == OP_RECORD) begin
						state_d = below ? S_IDLE : S_DIV;
					end else if (fraction_den == '0 || fraction_num > fraction_den ||
					             total_q == '0) begin
						state_d = S_OUT;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_DIV: if (div_done) state_d = (quo < VAL_BITS'(BUCKETS)) ? S_REC_RD : S_IDLE;
			S_REC_RD:   state_d = S_REC_WR;
			S_REC_WR:   state_d = S_IDLE;
			S_MUL:      if (mdone) state_d = S_QDIV;
			S_QDIV: begin
				if (div_done) begin
					state_d = ({1'b0, VAL_BITS'(under_q)} >= {1'b0, thr_fix}) ? S_OUT : S_WALK_RD;
				end
			end
			S_WALK_RD:  state_d = S_WALK_CHK;
			S_WALK_CHK: begin
				if (cum_next >= {1'b0, thr_q}) state_d = S_BMUL;
				else if (idx_q == (IW+1)'(BUCKETS - 1)) state_d = S_OUT;
				else state_d = S_WALK_RD;
			end
			S_BMUL:     if (mdone) state_d = S_BOUND;
			S_BOUND:    state_d = S_OUT;
			S_OUT:      state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			idx_q    <= '0;
			origin_q <= '0;
			width_q  <= FRAC_BITS'(1);
			total_q  <= '0;
			under_q  <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == S_OUT);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ORIGIN) origin_q <= cfg_data;
				else width_q <= cfg_data[FRAC_BITS-1:0];
			end
			unique case (state_q)
				S_CLEAR: idx_q <= idx_q + 1'b1;
				S_IDLE: begin
					idx_q <= '0;
					if (start && op == OP_RECORD) begin
						if (total_q != CNT_MAX) total_q <= total_q + 1'b1;
						if (below && under_q != CNT_MAX) under_q <= under_q + 1'b1;
					end
				end
				S_DIV: idx_q <= (IW+1)'(quo[IW-1:0]);
				S_WALK_CHK: begin
					if (!(cum_next >= {1'b0, thr_q})) idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem[idx_q[IW-1:0]] <= '0;
		end else if (state_q == S_REC_WR) begin
			mem[idx_q[IW-1:0]] <= (rd_q == CNT_MAX) ? rd_q : rd_q + 1'b1;
		end
		rd_q <= mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV) off_q <= off_q;
		if (state_q == S_IDLE && start) begin
			num_q    <= fraction_num;
			den_q    <= fraction_den;
			off_q    <= offset;
			status_q <= ST_NONE;
			lo_q     <= '0;
			hi_q     <= '0;
		end
		if (state_q == S_QDIV && div_done) begin
			thr_q <= thr_fix;
			cum_q <= {1'b0, VAL_BITS'(under_q)};
			if ({1'b0, VAL_BITS'(under_q)} >= {1'b0, thr_fix}) status_q <= ST_BELOW;
		end
		if (state_q == S_WALK_CHK) begin
			cum_q <= cum_next;
			if (cum_next < {1'b0, thr_q} && idx_q == (IW+1)'(BUCKETS - 1)) begin
				status_q <= ST_ABOVE;
			end
		end
		if (state_q == S_BMUL && mdone) begin
			ov_q <= !origin_q[VAL_BITS-1] && sum_lo[VAL_BITS-1];
			lo_q <= (!origin_q[VAL_BITS-1] && sum_lo[VAL_BITS-1]) ? SMAX : sum_lo;
		end
		if (state_q == S_BOUND) begin
			status_q <= ST_IN;
			hi_q <= (ov_q || (!lo_q[VAL_BITS-1] && sum_hi[VAL_BITS-1])) ? SMAX : sum_hi;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = (state_q == S_IDLE) && !start;
	assign out_valid   = valid_q;
	assign status      = status_q;
	assign lower_bound = lo_q;
	assign upper_bound = hi_q;

	a_out_after_ostate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid) else $error("result strobe missing");
	a_busy_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> busy) else $error("accept during clear");
	a_in_range_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_IN) |-> (lower_bound == '0 && upper_bound == '0))
		else $error("bounds not zero");
	a_under_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		under_q <= total_q) else $error("underflow exceeds total");
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV || state_q == S_QDIV) && !div_done) |-> div_busy)
		else $error("divider idle while waited on");
endmodule
